### rtl/rsbb_pkg.sv
// Shared types, constants and helper functions for the region bounding box block.
// No dependencies; every other file in rtl/ imports this package.
package rsbb_pkg;

	// coordinate, trig and arithmetic widths
	localparam int CW = 32;
	localparam int TW = 16;
	localparam int PW = CW + TW;
	localparam int SW = CW + TW + 3;

	// front to back queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	localparam int CORNERS = 4;

	// rounding shifts for rotated corners
	localparam int RECT_SHIFT = 14;
	localparam int ROT_SHIFT  = 15;

	// shape kind codes
	localparam logic [3:0] K_BOX         = 4'd0;
	localparam logic [3:0] K_RECT        = 4'd1;
	localparam logic [3:0] K_DIAMOND     = 4'd2;
	localparam logic [3:0] K_CIRCLE      = 4'd3;
	localparam logic [3:0] K_ANNULUS     = 4'd4;
	localparam logic [3:0] K_SECTOR      = 4'd5;
	localparam logic [3:0] K_ELLIPSE     = 4'd6;
	localparam logic [3:0] K_ELL_ANNULUS = 4'd7;
	localparam logic [3:0] K_LINE        = 4'd8;
	localparam logic [3:0] K_POINT       = 4'd9;
	localparam logic [3:0] K_POLYGON     = 4'd10;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [SW-1:0] sum_t;

	localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

	localparam sum_t RECT_HALF = SW'(2 ** (RECT_SHIFT - 1));
	localparam sum_t ROT_HALF  = SW'(2 ** (ROT_SHIFT - 1));

	// corner sign of one product term
	typedef enum logic [1:0] {
		SG_ZERO = 2'd0,
		SG_POS  = 2'd1,
		SG_NEG  = 2'd2
	} sgn_t;

	// box and rect corners, then diamond vertices
	localparam sgn_t BOX_P [CORNERS] = '{SG_NEG, SG_POS, SG_POS, SG_NEG};
	localparam sgn_t BOX_Q [CORNERS] = '{SG_POS, SG_POS, SG_NEG, SG_NEG};
	localparam sgn_t DIA_P [CORNERS] = '{SG_NEG, SG_ZERO, SG_POS, SG_ZERO};
	localparam sgn_t DIA_Q [CORNERS] = '{SG_ZERO, SG_POS, SG_ZERO, SG_NEG};

	// what the region result will be, settled in the front
	typedef enum logic [1:0] {
		ST_EMPTY     = 2'd0,
		ST_BOX       = 2'd1,
		ST_ERROR     = 2'd2,
		ST_UNBOUNDED = 2'd3
	} stat_t;

	// one classified shape travelling from front to back
	typedef struct packed {
		logic   last;
		logic   use_ext;
		stat_t  stat;
		logic   rot;
		logic   diamond;
		logic   rect;
		prod_t  prod_a;
		prod_t  prod_b;
		prod_t  prod_c;
		prod_t  prod_d;
		sum_t   base_x;
		sum_t   base_y;
		coord_t ext_min_x;
		coord_t ext_max_x;
		coord_t ext_min_y;
		coord_t ext_max_y;
	} rsbb_item_t;

	// apply a corner sign to a product
	function automatic sum_t sgn_apply(input sgn_t g, input prod_t v);
		sum_t r;
		unique case (g)
			SG_POS:  r = SW'(v);
			SG_NEG:  r = -SW'(v);
			default: r = '0;
		endcase
		return r;
	endfunction

	// floor-shift a corner sum and saturate to the coordinate range
	function automatic coord_t sat_corner(input sum_t v, input logic rect);
		sum_t sh;
		sh = rect ? (v >>> RECT_SHIFT) : (v >>> ROT_SHIFT);
		if (sh > SW'(COORD_MAX))
			return COORD_MAX;
		if (sh < SW'(COORD_MIN))
			return COORD_MIN;
		return sh[CW-1:0];
	endfunction

	// saturating add or subtract of two coordinates
	function automatic coord_t sat_sum(input coord_t a, input coord_t b, input logic sub);
		logic signed [CW:0] s;
		s = sub ? ((CW+1)'(a) - (CW+1)'(b)) : ((CW+1)'(a) + (CW+1)'(b));
		if (s[CW] != s[CW-1])
			return s[CW] ? COORD_MIN : COORD_MAX;
		return s[CW-1:0];
	endfunction

	function automatic coord_t cmin(input coord_t a, input coord_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic coord_t cmax(input coord_t a, input coord_t b);
		return (a > b) ? a : b;
	endfunction

endpackage

### rtl/rsbb_front.sv
// Front end: accepts shapes, tracks region flags, forms products and direct extents.
// Depends on rsbb_pkg.
module rsbb_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [3:0]                shape_kind,
	input  logic                      included,
	input  logic signed [rsbb_pkg::CW-1:0] pos_x,
	input  logic signed [rsbb_pkg::CW-1:0] pos_y,
	input  logic signed [rsbb_pkg::CW-1:0] size_one,
	input  logic signed [rsbb_pkg::CW-1:0] size_two,
	input  logic signed [rsbb_pkg::CW-1:0] size_three,
	input  logic signed [rsbb_pkg::CW-1:0] size_four,
	input  logic signed [rsbb_pkg::TW-1:0] sin_angle,
	input  logic signed [rsbb_pkg::TW-1:0] cos_angle,
	input  logic                      last_shape,
	output logic                      item_valid,
	output rsbb_pkg::rsbb_item_t      item,
	input  logic                      item_ready
);
	import rsbb_pkg::*;

	logic       v_s1;
	rsbb_item_t item_s1;
	logic       awaiting_q, unb_q, err_q, contrib_q;

	logic   accept;
	logic   is_rot, is_rect, is_diamond, is_round, is_sector, is_line, is_point, is_poly;
	logic   got, unb_now, err_now, use_now, contrib_now;
	stat_t  stat_now;
	coord_t radius;
	coord_t xmn, xmx, ymn, ymx;
	prod_t  prod_a, prod_b, prod_c, prod_d;
	sum_t   base_x, base_y;

	assign in_ready   = !v_s1 || item_ready;
	assign accept     = in_valid && in_ready;
	assign item_valid = v_s1;
	assign item       = item_s1;

	// decode the shape kind
	always_comb begin
		is_rot     = 1'b0;
		is_rect    = 1'b0;
		is_diamond = 1'b0;
		is_round   = 1'b0;
		is_sector  = 1'b0;
		is_line    = 1'b0;
		is_point   = 1'b0;
		is_poly    = 1'b0;
		unique case (shape_kind) inside
			K_BOX: begin
				is_rot = 1'b1;
			end
			K_RECT: begin
				is_rot  = 1'b1;
				is_rect = 1'b1;
			end
			K_DIAMOND: begin
				is_rot     = 1'b1;
				is_diamond = 1'b1;
			end
			K_CIRCLE, K_ANNULUS, K_ELLIPSE, K_ELL_ANNULUS: begin
				is_round = 1'b1;
			end
			K_SECTOR: begin
				is_sector = 1'b1;
			end
			K_LINE: begin
				is_line = 1'b1;
			end
			K_POINT: begin
				is_point = 1'b1;
			end
			K_POLYGON: begin
				is_poly = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign got = is_rot || is_round || is_line || is_point || is_poly;

	// pick the largest radius of a round shape
	always_comb begin
		radius = size_one;
		if (shape_kind != K_CIRCLE && size_two > radius)
			radius = size_two;
		if (shape_kind == K_ELL_ANNULUS && size_three > radius)
			radius = size_three;
		if (shape_kind == K_ELL_ANNULUS && size_four > radius)
			radius = size_four;
	end

	// extents of shapes that need no rotation
	always_comb begin
		if (is_round) begin
			xmn = sat_sum(pos_x, radius, 1'b1);
			xmx = sat_sum(pos_x, radius, 1'b0);
			ymn = sat_sum(pos_y, radius, 1'b1);
			ymx = sat_sum(pos_y, radius, 1'b0);
		end else if (is_line) begin
			xmn = cmin(pos_x, size_one);
			xmx = cmax(pos_x, size_one);
			ymn = cmin(pos_y, size_two);
			ymx = cmax(pos_y, size_two);
		end else if (is_point) begin
			xmn = pos_x;
			xmx = pos_x;
			ymn = pos_y;
			ymx = pos_y;
		end else begin
			xmn = pos_x;
			xmx = size_one;
			ymn = pos_y;
			ymx = size_two;
		end
	end

	// rotation products and rounded centre terms
	assign prod_a = PW'(size_one) * PW'(cos_angle);
	assign prod_b = PW'(size_two) * PW'(sin_angle);
	assign prod_c = PW'(size_one) * PW'(sin_angle);
	assign prod_d = PW'(size_two) * PW'(cos_angle);
	assign base_x = is_rect ? ((SW'(pos_x) <<< RECT_SHIFT) + RECT_HALF)
	                        : ((SW'(pos_x) <<< ROT_SHIFT) + ROT_HALF);
	assign base_y = is_rect ? ((SW'(pos_y) <<< RECT_SHIFT) + RECT_HALF)
	                        : ((SW'(pos_y) <<< ROT_SHIFT) + ROT_HALF);

	// region flags as they stand after this item
	always_comb begin
		unb_now     = awaiting_q ? !included : unb_q;
		err_now     = err_q || (!unb_now && is_sector);
		use_now     = got && !unb_now && !err_q;
		contrib_now = contrib_q || use_now;
		if (unb_now)
			stat_now = ST_UNBOUNDED;
		else if (err_now)
			stat_now = ST_ERROR;
		else if (contrib_now)
			stat_now = ST_BOX;
		else
			stat_now = ST_EMPTY;
	end

	// hold the stage valid and the region flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			awaiting_q <= 1'b1;
			unb_q      <= 1'b0;
			err_q      <= 1'b0;
			contrib_q  <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (accept) begin
				if (last_shape) begin
					awaiting_q <= 1'b1;
					unb_q      <= 1'b0;
					err_q      <= 1'b0;
					contrib_q  <= 1'b0;
				end else begin
					awaiting_q <= 1'b0;
					unb_q      <= unb_now;
					err_q      <= err_now;
					contrib_q  <= contrib_now;
				end
			end
		end
	end

	// load the classified item
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.last      <= last_shape;
			item_s1.use_ext   <= use_now;
			item_s1.stat      <= stat_now;
			item_s1.rot       <= is_rot;
			item_s1.diamond   <= is_diamond;
			item_s1.rect      <= is_rect;
			item_s1.prod_a    <= prod_a;
			item_s1.prod_b    <= prod_b;
			item_s1.prod_c    <= prod_c;
			item_s1.prod_d    <= prod_d;
			item_s1.base_x    <= base_x;
			item_s1.base_y    <= base_y;
			item_s1.ext_min_x <= xmn;
			item_s1.ext_max_x <= xmx;
			item_s1.ext_min_y <= ymn;
			item_s1.ext_max_y <= ymx;
		end
	end

endmodule

### rtl/rsbb_fifo.sv
// Short register queue between front and back end.
// Depends on rsbb_pkg.
module rsbb_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	input  rsbb_pkg::rsbb_item_t push_item,
	output logic                 push_ready,
	input  logic                 pop,
	output logic                 pop_valid,
	output rsbb_pkg::rsbb_item_t pop_item
);
	import rsbb_pkg::*;

	rsbb_item_t       mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign push_ready = (cnt_q != CNT_W'(FIFO_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// store the pushed item
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

### rtl/rsbb_back.sv
// Back end: rotated corners, per-shape extent, running box and the result register.
// Depends on rsbb_pkg.
module rsbb_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_valid,
	input  rsbb_pkg::rsbb_item_t      q_item,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [rsbb_pkg::CW-1:0] min_x,
	output logic signed [rsbb_pkg::CW-1:0] max_x,
	output logic signed [rsbb_pkg::CW-1:0] min_y,
	output logic signed [rsbb_pkg::CW-1:0] max_y,
	output logic                      bounded,
	output logic                      error
);
	import rsbb_pkg::*;

	logic en;

	// corner stage
	logic   v_s2, last_s2, use_s2, rot_s2;
	stat_t  stat_s2;
	coord_t cx_s2 [CORNERS];
	coord_t cy_s2 [CORNERS];
	coord_t emn_x_s2, emx_x_s2, emn_y_s2, emx_y_s2;
	coord_t cx [CORNERS];
	coord_t cy [CORNERS];

	// extent stage
	logic   v_s3, last_s3, use_s3;
	stat_t  stat_s3;
	coord_t xmn_s3, xmx_s3, ymn_s3, ymx_s3;
	coord_t xmn, xmx, ymn, ymx;

	// running box and result
	coord_t run_min_x_q, run_max_x_q, run_min_y_q, run_max_y_q;
	coord_t mrg_min_x, mrg_max_x, mrg_min_y, mrg_max_y;
	logic   out_valid_q, bounded_q, error_q;
	coord_t min_x_q, max_x_q, min_y_q, max_y_q;

	// stall the whole back end only while a result waits
	assign en    = !out_valid_q || out_ready;
	assign q_pop = en && q_valid;

	// four corner points of a rotated shape
	always_comb begin
		sgn_t gp, gq;
		sum_t tx, ty;
		for (int i = 0; i < CORNERS; i++) begin
			gp    = q_item.diamond ? DIA_P[i] : BOX_P[i];
			gq    = q_item.diamond ? DIA_Q[i] : BOX_Q[i];
			tx    = sgn_apply(gp, q_item.prod_a) - sgn_apply(gq, q_item.prod_b) + q_item.base_x;
			ty    = sgn_apply(gp, q_item.prod_c) + sgn_apply(gq, q_item.prod_d) + q_item.base_y;
			cx[i] = sat_corner(tx, q_item.rect);
			cy[i] = sat_corner(ty, q_item.rect);
		end
	end

	// extent: corner min and max, or passed through
	always_comb begin
		if (rot_s2) begin
			xmn = cmin(cmin(cx_s2[0], cx_s2[1]), cmin(cx_s2[2], cx_s2[3]));
			xmx = cmax(cmax(cx_s2[0], cx_s2[1]), cmax(cx_s2[2], cx_s2[3]));
			ymn = cmin(cmin(cy_s2[0], cy_s2[1]), cmin(cy_s2[2], cy_s2[3]));
			ymx = cmax(cmax(cy_s2[0], cy_s2[1]), cmax(cy_s2[2], cy_s2[3]));
		end else begin
			xmn = emn_x_s2;
			xmx = emx_x_s2;
			ymn = emn_y_s2;
			ymx = emx_y_s2;
		end
	end

	// merge the extent into the running box
	always_comb begin
		mrg_min_x = (use_s3 && xmn_s3 < run_min_x_q) ? xmn_s3 : run_min_x_q;
		mrg_max_x = (use_s3 && xmx_s3 > run_max_x_q) ? xmx_s3 : run_max_x_q;
		mrg_min_y = (use_s3 && ymn_s3 < run_min_y_q) ? ymn_s3 : run_min_y_q;
		mrg_max_y = (use_s3 && ymx_s3 > run_max_y_q) ? ymx_s3 : run_max_y_q;
	end

	// stage valids, running box and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			run_min_x_q <= COORD_MAX;
			run_max_x_q <= COORD_MIN;
			run_min_y_q <= COORD_MAX;
			run_max_y_q <= COORD_MIN;
		end else if (en) begin
			v_s2        <= q_valid;
			v_s3        <= v_s2;
			out_valid_q <= v_s3 && last_s3;
			if (v_s3) begin
				if (last_s3) begin
					run_min_x_q <= COORD_MAX;
					run_max_x_q <= COORD_MIN;
					run_min_y_q <= COORD_MAX;
					run_max_y_q <= COORD_MIN;
				end else begin
					run_min_x_q <= mrg_min_x;
					run_max_x_q <= mrg_max_x;
					run_min_y_q <= mrg_min_y;
					run_max_y_q <= mrg_max_y;
				end
			end
		end
	end

	// advance the stage payloads
	always_ff @(posedge clk) begin
		if (en) begin
			last_s2  <= q_item.last;
			use_s2   <= q_item.use_ext;
			stat_s2  <= q_item.stat;
			rot_s2   <= q_item.rot;
			cx_s2    <= cx;
			cy_s2    <= cy;
			emn_x_s2 <= q_item.ext_min_x;
			emx_x_s2 <= q_item.ext_max_x;
			emn_y_s2 <= q_item.ext_min_y;
			emx_y_s2 <= q_item.ext_max_y;

			last_s3 <= last_s2;
			use_s3  <= use_s2;
			stat_s3 <= stat_s2;
			xmn_s3  <= xmn;
			xmx_s3  <= xmx;
			ymn_s3  <= ymn;
			ymx_s3  <= ymx;
		end
	end

	// load the result on the last item of a region
	always_ff @(posedge clk) begin
		if (en && v_s3 && last_s3) begin
			unique case (stat_s3) inside
				ST_BOX: begin
					min_x_q   <= mrg_min_x;
					max_x_q   <= mrg_max_x;
					min_y_q   <= mrg_min_y;
					max_y_q   <= mrg_max_y;
					bounded_q <= 1'b1;
					error_q   <= 1'b0;
				end
				ST_ERROR: begin
					min_x_q   <= '0;
					max_x_q   <= '0;
					min_y_q   <= '0;
					max_y_q   <= '0;
					bounded_q <= 1'b1;
					error_q   <= 1'b1;
				end
				ST_EMPTY, ST_UNBOUNDED: begin
					min_x_q   <= '0;
					max_x_q   <= '0;
					min_y_q   <= '0;
					max_y_q   <= '0;
					bounded_q <= 1'b0;
					error_q   <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign min_x     = min_x_q;
	assign max_x     = max_x_q;
	assign min_y     = min_y_q;
	assign max_y     = max_y_q;
	assign bounded   = bounded_q;
	assign error     = error_q;

endmodule

### rtl/region_shape_bounding_box.sv
// Region bounding box: one shape per item, one box per region on its last item.
// Throughput: one item per cycle unless a result waits; the front multiplies
// once per item and the back updates the running box with one compare per coordinate
// each cycle. The result register follows the front register, queue and back stages.
// While a result waits, the front keeps accepting until the 4-entry queue fills.
// Reset (arst_n low, asynchronous) empties the pipeline and starts a fresh region.
module region_shape_bounding_box (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [3:0]                shape_kind,
	input  logic                      included,
	input  logic signed [rsbb_pkg::CW-1:0] pos_x,
	input  logic signed [rsbb_pkg::CW-1:0] pos_y,
	input  logic signed [rsbb_pkg::CW-1:0] size_one,
	input  logic signed [rsbb_pkg::CW-1:0] size_two,
	input  logic signed [rsbb_pkg::CW-1:0] size_three,
	input  logic signed [rsbb_pkg::CW-1:0] size_four,
	input  logic signed [rsbb_pkg::TW-1:0] sin_angle,
	input  logic signed [rsbb_pkg::TW-1:0] cos_angle,
	input  logic                      last_shape,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [rsbb_pkg::CW-1:0] min_x,
	output logic signed [rsbb_pkg::CW-1:0] max_x,
	output logic signed [rsbb_pkg::CW-1:0] min_y,
	output logic signed [rsbb_pkg::CW-1:0] max_y,
	output logic                      bounded,
	output logic                      error
);
	import rsbb_pkg::*;

	logic       f_valid, f_ready;
	rsbb_item_t f_item;
	logic       q_valid, q_pop;
	rsbb_item_t q_item;

	// accept and classify
	rsbb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.shape_kind (shape_kind),
		.included   (included),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.size_one   (size_one),
		.size_two   (size_two),
		.size_three (size_three),
		.size_four  (size_four),
		.sin_angle  (sin_angle),
		.cos_angle  (cos_angle),
		.last_shape (last_shape),
		.item_valid (f_valid),
		.item       (f_item),
		.item_ready (f_ready)
	);

	// decouple front and back
	rsbb_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_item  (f_item),
		.push_ready (f_ready),
		.pop        (q_pop),
		.pop_valid  (q_valid),
		.pop_item   (q_item)
	);

	// corners, extent, running box, result
	rsbb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.min_x     (min_x),
		.max_x     (max_x),
		.min_y     (min_y),
		.max_y     (max_y),
		.bounded   (bounded),
		.error     (error)
	);

endmodule

### tb/region_shape_bounding_box_tb.sv
// Self-checking bench for region_shape_bounding_box: directed and random shape streams,
// a bounding-box scoreboard class, and random stalls on both handshakes.
// Depends on rtl/rsbb_pkg.sv and rtl/region_shape_bounding_box.sv.
`timescale 1ns / 1ps

module region_shape_bounding_box_tb;
	import rsbb_pkg::*;

	typedef logic signed [TW-1:0] trig_t;

	// one shape as driven on the input channel
	typedef struct {
		logic [3:0] kind;
		logic       inc;
		coord_t     px;
		coord_t     py;
		coord_t     s1;
		coord_t     s2;
		coord_t     s3;
		coord_t     s4;
		trig_t      sn;
		trig_t      cs;
		logic       last;
	} shape_t;

	// one region box as seen on the output channel
	typedef struct {
		coord_t lo_x;
		coord_t hi_x;
		coord_t lo_y;
		coord_t hi_y;
		logic   bounded;
		logic   err;
	} bbox_t;

	localparam logic [3:0] K_FIRST_UNUSED = 4'd11;
	localparam logic [3:0] K_LAST_UNUSED  = 4'd15;
	localparam coord_t Q16_ONE = 32'sh0001_0000;
	localparam trig_t  Q14_ONE = 16'sd16384;
	localparam trig_t  Q14_R2  = 16'sd11585;
	localparam int     WATCHDOG_LIMIT = 1000;
	localparam int     RANDOM_ITEMS   = 850;

	// running box of the open region and the boxes still due
	class bbox_tracker;
		longint run_lo_x, run_hi_x, run_lo_y, run_hi_y;
		bit     first_due, excluded, sector_hit, any_extent;
		bbox_t  boxes_due[$];
		int     mismatches;

		function new();
			mismatches = 0;
			start_region();
		endfunction

		function void start_region();
			run_lo_x = longint'(COORD_MAX);
			run_hi_x = longint'(COORD_MIN);
			run_lo_y = longint'(COORD_MAX);
			run_hi_y = longint'(COORD_MIN);
			first_due = 1'b1;
			excluded = 1'b0;
			sector_hit = 1'b0;
			any_extent = 1'b0;
		endfunction

		static function longint clamp(longint v);
			if (v > longint'(COORD_MAX))
				return longint'(COORD_MAX);
			if (v < longint'(COORD_MIN))
				return longint'(COORD_MIN);
			return v;
		endfunction

		// floor((a*ca + b*cb + ctr*2^sh + 2^(sh-1)) / 2^sh), clamped
		static function longint rotate_term(longint a, longint ca, longint b, longint cb,
				longint ctr, int sh);
			longint acc;
			acc = a * ca + b * cb + ctr * (longint'(1) << sh) + (longint'(1) << (sh - 1));
			return clamp(acc >>> sh);
		endfunction

		// fold one accepted shape into the region; queue the box on the last one
		function void take_shape(shape_t s);
			longint px, py, s1, s2, s3, s4, sn, cs;
			longint xl, xh, yl, yh, cx, cy, r;
			int     p, q, sh;
			bit     got;
			bbox_t  box;
			px = s.px; py = s.py; s1 = s.s1; s2 = s.s2; s3 = s.s3; s4 = s.s4;
			sn = s.sn; cs = s.cs;
			xl = longint'(COORD_MAX); xh = longint'(COORD_MIN);
			yl = longint'(COORD_MAX); yh = longint'(COORD_MIN);
			got = 1'b0;
			if (first_due) begin
				first_due = 1'b0;
				if (!s.inc)
					excluded = 1'b1;
			end
			if (!excluded && !sector_hit) begin
				case (s.kind)
					K_BOX, K_RECT, K_DIAMOND: begin
						sh = (s.kind == K_RECT) ? RECT_SHIFT : ROT_SHIFT;
						for (int i = 0; i < 4; i++) begin
							// box corners, or the four diamond vertices
							if (s.kind == K_DIAMOND) begin
								p = (i == 0) ? -1 : (i == 2) ? 1 : 0;
								q = (i == 1) ? 1 : (i == 3) ? -1 : 0;
							end else begin
								p = (i == 1 || i == 2) ? 1 : -1;
								q = (i < 2) ? 1 : -1;
							end
							cx = rotate_term(s1, p * cs, s2, -q * sn, px, sh);
							cy = rotate_term(s1, p * sn, s2, q * cs, py, sh);
							if (cx < xl) xl = cx;
							if (cx > xh) xh = cx;
							if (cy < yl) yl = cy;
							if (cy > yh) yh = cy;
						end
						got = 1'b1;
					end
					K_CIRCLE, K_ANNULUS, K_ELLIPSE, K_ELL_ANNULUS: begin
						r = s1;
						if (s.kind != K_CIRCLE && s2 > r) r = s2;
						if (s.kind == K_ELL_ANNULUS && s3 > r) r = s3;
						if (s.kind == K_ELL_ANNULUS && s4 > r) r = s4;
						xl = clamp(px - r);
						xh = clamp(px + r);
						yl = clamp(py - r);
						yh = clamp(py + r);
						got = 1'b1;
					end
					K_SECTOR: sector_hit = 1'b1;
					K_LINE: begin
						xl = (px < s1) ? px : s1;
						xh = (px > s1) ? px : s1;
						yl = (py < s2) ? py : s2;
						yh = (py > s2) ? py : s2;
						got = 1'b1;
					end
					K_POINT: begin
						xl = px; xh = px; yl = py; yh = py;
						got = 1'b1;
					end
					K_POLYGON: begin
						xl = px; xh = s1; yl = py; yh = s2;
						got = 1'b1;
					end
					default: ;
				endcase
				if (got) begin
					if (xl < run_lo_x) run_lo_x = xl;
					if (xh > run_hi_x) run_hi_x = xh;
					if (yl < run_lo_y) run_lo_y = yl;
					if (yh > run_hi_y) run_hi_y = yh;
					any_extent = 1'b1;
				end
			end
			if (!s.last)
				return;
			box.lo_x = '0; box.hi_x = '0; box.lo_y = '0; box.hi_y = '0;
			box.bounded = 1'b0; box.err = 1'b0;
			if (excluded) begin
				// unbounded region: all zero
			end else if (sector_hit) begin
				box.bounded = 1'b1;
				box.err = 1'b1;
			end else if (any_extent) begin
				box.lo_x = coord_t'(run_lo_x);
				box.hi_x = coord_t'(run_hi_x);
				box.lo_y = coord_t'(run_lo_y);
				box.hi_y = coord_t'(run_hi_y);
				box.bounded = 1'b1;
			end
			boxes_due.push_back(box);
			start_region();
		endfunction

		function void compare(string name, longint want, longint got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		// match one result against the oldest box due
		function void check_box(bbox_t got);
			bbox_t want;
			if (boxes_due.size() == 0) begin
				$error("box result with no region pending");
				mismatches++;
				return;
			end
			want = boxes_due.pop_front();
			compare("min_x", want.lo_x, got.lo_x);
			compare("max_x", want.hi_x, got.hi_x);
			compare("min_y", want.lo_y, got.lo_y);
			compare("max_y", want.hi_y, got.hi_y);
			compare("bounded", want.bounded, got.bounded);
			compare("error", want.err, got.err);
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [3:0] shape_kind;
	logic       included;
	coord_t     pos_x, pos_y, size_one, size_two, size_three, size_four;
	trig_t      sin_angle, cos_angle;
	logic       last_shape;
	logic       out_valid;
	logic       out_ready;
	coord_t     min_x, max_x, min_y, max_y;
	logic       bounded;
	logic       error;

	bbox_tracker tracker;
	bbox_t       observed;
	int          quiet_cycles = 0;

	region_shape_bounding_box dut (.*);

	always #5 clk = ~clk;

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("region_shape_bounding_box verification failed");
			$finish;
		end
	end

	// check every accepted box
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			observed.lo_x = min_x;
			observed.hi_x = max_x;
			observed.lo_y = min_y;
			observed.hi_y = max_y;
			observed.bounded = bounded;
			observed.err = error;
			tracker.check_box(observed);
		end
	end

	// stall the result side at random, with calm windows
	initial begin : result_side
		int stall;
		int cyc;
		stall = 0;
		cyc = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (stall > 0) begin
				out_ready = 1'b0;
				stall--;
			end else begin
				out_ready = 1'b1;
				if ((cyc % 400) < 300 && $urandom_range(0, 4) == 0)
					stall = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 40)
						: $urandom_range(1, 3);
			end
		end
	end

	function automatic shape_t shape_of(logic [3:0] kind, logic inc, logic last,
			coord_t px, coord_t py, coord_t s1, coord_t s2,
			trig_t sn = 0, trig_t cs = Q14_ONE, coord_t s3 = 0, coord_t s4 = 0);
		shape_t s;
		s.kind = kind; s.inc = inc; s.last = last;
		s.px = px; s.py = py; s.s1 = s1; s.s2 = s2; s.s3 = s3; s.s4 = s4;
		s.sn = sn; s.cs = cs;
		return s;
	endfunction

	function automatic logic [3:0] rand_kind();
		int v;
		v = $urandom_range(0, 99);
		if (v < 3)
			return K_SECTOR;
		if (v < 6)
			return 4'($urandom_range(K_FIRST_UNUSED, K_LAST_UNUSED));
		case (v % 10)
			0: return K_BOX;
			1: return K_RECT;
			2: return K_DIAMOND;
			3: return K_CIRCLE;
			4: return K_ANNULUS;
			5: return K_ELLIPSE;
			6: return K_ELL_ANNULUS;
			7: return K_LINE;
			8: return K_POINT;
			default: return K_POLYGON;
		endcase
	endfunction

	function automatic coord_t rand_coord();
		int v;
		v = $urandom_range(0, 99);
		if (v < 45)
			return coord_t'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
		if (v < 70)
			return coord_t'($urandom());
		if (v < 85) begin
			case ($urandom_range(0, 4))
				0: return COORD_MAX;
				1: return COORD_MIN;
				2: return 0;
				3: return -1;
				default: return 1;
			endcase
		end
		return coord_t'($urandom_range(0, 32'h1FFF_FFFF)) - 32'sh1000_0000;
	endfunction

	function automatic coord_t rand_radius();
		int v;
		v = $urandom_range(0, 99);
		if (v < 70)
			return coord_t'($urandom_range(0, 32'h003F_FFFF));
		if (v < 82)
			return -coord_t'($urandom_range(1, 32'h0003_FFFF));
		if (v < 90)
			return ($urandom_range(0, 1) != 0) ? COORD_MAX : COORD_MIN;
		return coord_t'($urandom());
	endfunction

	function automatic trig_t rand_trig();
		int v;
		v = $urandom_range(0, 99);
		if (v < 70)
			return trig_t'(int'($urandom_range(0, 32768)) - 16384);
		if (v < 85) begin
			case ($urandom_range(0, 4))
				0: return Q14_ONE;
				1: return -Q14_ONE;
				2: return 0;
				3: return Q14_R2;
				default: return -Q14_R2;
			endcase
		end
		return trig_t'($urandom());
	endfunction

	function automatic shape_t rand_shape(bit first, bit last);
		shape_t s;
		s.kind = rand_kind();
		s.inc = first ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
		s.last = last;
		s.px = rand_coord();
		s.py = rand_coord();
		s.s3 = rand_radius();
		s.s4 = rand_radius();
		s.sn = rand_trig();
		s.cs = rand_trig();
		if (s.kind == K_LINE || s.kind == K_POLYGON) begin
			s.s1 = rand_coord();
			s.s2 = rand_coord();
			// keep most polygon boxes in order
			if (s.kind == K_POLYGON && $urandom_range(0, 4) != 0) begin
				if (s.s1 < s.px) {s.px, s.s1} = {s.s1, s.px};
				if (s.s2 < s.py) {s.py, s.s2} = {s.s2, s.py};
			end
		end else begin
			s.s1 = rand_radius();
			s.s2 = rand_radius();
		end
		return s;
	endfunction

	function automatic int pick_gap(bit calm);
		int v;
		v = $urandom_range(0, 99);
		if (calm || v < 60)
			return 0;
		if (v < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// present one shape and hold it until accepted
	task automatic send_shape(shape_t s);
		@(negedge clk);
		in_valid = 1'b1;
		shape_kind = s.kind;
		included = s.inc;
		pos_x = s.px;
		pos_y = s.py;
		size_one = s.s1;
		size_two = s.s2;
		size_three = s.s3;
		size_four = s.s4;
		sin_angle = s.sn;
		cos_angle = s.cs;
		last_shape = s.last;
		do @(posedge clk); while (!in_ready);
		tracker.take_shape(s);
	endtask

	task automatic idle_sender(int n);
		if (n > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// hold off the sender until every box due has come out
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.boxes_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		shape_t s;
		int     counted, region_no, len;
		bit     calm;
		tracker = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		shape_kind = '0;
		included = 1'b0;
		pos_x = '0;
		pos_y = '0;
		size_one = '0;
		size_two = '0;
		size_three = '0;
		size_four = '0;
		sin_angle = '0;
		cos_angle = '0;
		last_shape = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one region through every defined extent rule
		send_shape(shape_of(K_BOX, 1, 0, 0, 0, 4 * Q16_ONE, 2 * Q16_ONE));
		send_shape(shape_of(K_RECT, 1, 0, Q16_ONE, -Q16_ONE, Q16_ONE / 2, 3 * Q16_ONE / 2,
			Q14_R2, Q14_R2));
		send_shape(shape_of(K_DIAMOND, 1, 0, -3 * Q16_ONE, Q16_ONE / 4, 6 * Q16_ONE,
			2 * Q16_ONE, -Q14_ONE, 0));
		send_shape(shape_of(K_CIRCLE, 1, 0, 16 * Q16_ONE, 0, Q16_ONE, 0));
		send_shape(shape_of(K_ANNULUS, 1, 0, 0, 20 * Q16_ONE, Q16_ONE, 3 * Q16_ONE));
		send_shape(shape_of(K_ELLIPSE, 1, 0, -20 * Q16_ONE, 0, 5 * Q16_ONE, 2 * Q16_ONE));
		send_shape(shape_of(K_ELL_ANNULUS, 1, 0, 0, -20 * Q16_ONE, Q16_ONE, 2 * Q16_ONE,
			0, Q14_ONE, 3 * Q16_ONE, 7 * Q16_ONE));
		// line with its end points reversed
		send_shape(shape_of(K_LINE, 1, 0, 7 * Q16_ONE, 30 * Q16_ONE, -7 * Q16_ONE,
			-30 * Q16_ONE));
		send_shape(shape_of(K_POINT, 1, 0, 40 * Q16_ONE, -40 * Q16_ONE, 0, 0));
		send_shape(shape_of(K_POLYGON, 1, 1, -2 * Q16_ONE, -2 * Q16_ONE, 3 * Q16_ONE,
			5 * Q16_ONE));
		// corners past both ends of the range, sine and cosine out of range
		send_shape(shape_of(K_BOX, 1, 1, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
			-32768, 32767));
		// saturating circle, then a polygon box given reversed
		send_shape(shape_of(K_CIRCLE, 1, 0, COORD_MIN, COORD_MAX, COORD_MAX, 0));
		send_shape(shape_of(K_POLYGON, 1, 1, 9 * Q16_ONE, 9 * Q16_ONE, -9 * Q16_ONE,
			-9 * Q16_ONE));
		// excluded first shape makes the region unbounded
		send_shape(shape_of(K_POINT, 0, 0, Q16_ONE, Q16_ONE, 0, 0));
		send_shape(shape_of(K_BOX, 1, 1, 0, 0, Q16_ONE, Q16_ONE));
		// sector flags the region and masks what follows
		send_shape(shape_of(K_BOX, 1, 0, 0, 0, Q16_ONE, Q16_ONE));
		send_shape(shape_of(K_SECTOR, 1, 0, 0, 0, Q16_ONE, Q16_ONE));
		send_shape(shape_of(K_POINT, 1, 1, 5 * Q16_ONE, 5 * Q16_ONE, 0, 0));
		// undefined kinds only: no extent at all
		send_shape(shape_of(K_FIRST_UNUSED, 1, 0, Q16_ONE, Q16_ONE, Q16_ONE, Q16_ONE));
		send_shape(shape_of(K_LAST_UNUSED, 1, 1, -1, -1, -1, -1));
		// negative radius leaves min above max
		send_shape(shape_of(K_CIRCLE, 1, 1, 0, 0, -2 * Q16_ONE, 0));
		// most negative sine and cosine, then negative radii only
		send_shape(shape_of(K_RECT, 1, 0, -1, 1, COORD_MAX, COORD_MIN, -32768, -32768));
		send_shape(shape_of(K_ELL_ANNULUS, 1, 1, 0, 0, -Q16_ONE, -2 * Q16_ONE, 0, Q14_ONE,
			-3 * Q16_ONE, -Q16_ONE));
		drain_results();

		// random regions, mostly short, with random gaps
		counted = 0;
		region_no = 0;
		while (counted < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
			calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < len; k++) begin
				s = rand_shape(k == 0, k == len - 1);
				counted++;
				send_shape(s);
				idle_sender(pick_gap(calm));
			end
			region_no++;
			if (region_no == 60 || $urandom_range(0, 19) == 0)
				drain_results();
		end

		// let the pipeline empty, then judge
		@(negedge clk);
		in_valid = 1'b0;
		while (tracker.boxes_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0)
			$display("region_shape_bounding_box verification clean");
		else
			$display("region_shape_bounding_box verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/rsbb_pkg.sv
rtl/rsbb_front.sv
rtl/rsbb_fifo.sv
rtl/rsbb_back.sv
rtl/region_shape_bounding_box.sv
tb/region_shape_bounding_box_tb.sv
